// File: rtl/core/crrs_pkg.sv
`timescale 1ns / 1ps

package crrs_pkg;

  localparam int SlotCountDefault = 8;
  localparam int IdWidth          = 29;
  localparam int LenWidth         = 4;
  localparam int ByteCount        = 8;
  localparam int DataWidth        = 8 * ByteCount;
  localparam int SlotFieldWidth   = 3;

  typedef enum logic [0:0] {
    OP_FRAME   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_APPEND,
    ST_OPEN,
    ST_REL_RD,
    ST_REL_CHK
  } state_e;

  typedef struct packed {
    opcode_e                     opcode;
    logic [IdWidth-1:0]          frame_id;
    logic [LenWidth-1:0]         frame_len;
    logic [DataWidth-1:0]        frame_bytes;
    logic [SlotFieldWidth-1:0]   release_index;
  } frame_t;

  typedef struct packed {
    logic                        appended;
    logic [SlotFieldWidth-1:0]   appended_slot;
    logic [LenWidth-1:0]         appended_count;
    logic                        opened;
    logic [SlotFieldWidth-1:0]   opened_slot;
    logic [LenWidth-1:0]         opened_count;
    logic [LenWidth-1:0]         dropped_count;
    logic [IdWidth-1:0]          slot_id_out;
    logic [DataWidth-1:0]        slot_bytes_out;
    logic [ByteCount-1:0]        slot_mask_out;
  } result_t;

  typedef struct packed {
    logic [IdWidth-1:0]   ident;
    logic [DataWidth-1:0] payload;
    logic [ByteCount-1:0] mask;
  } slot_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic chk;
    logic wr_app;
    logic wr_open;
    logic rel;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_rel;
    logic in_trivial;
    logic hit;
    logic last;
  } status_t;

  function automatic logic [DataWidth-1:0] byte_mask(input logic [LenWidth-1:0] n);
    logic [DataWidth-1:0] m;
    m = '0;
    for (int k = 0; k < ByteCount; k++) begin
      m[8*k +: 8] = (LenWidth'(k) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [ByteCount-1:0] bit_mask(input logic [LenWidth-1:0] n);
    logic [ByteCount-1:0] m;
    m = '0;
    for (int k = 0; k < ByteCount; k++) begin
      m[k] = (LenWidth'(k) < n);
    end
    return m;
  endfunction

  function automatic logic [LenWidth-1:0] fill_level(input logic [ByteCount-1:0] mask);
    logic [LenWidth-1:0] lvl;
    lvl = '0;
    for (int p = 0; p < ByteCount; p++) begin
      if (mask[p]) begin
        lvl = LenWidth'(p + 1);
      end
    end
    return lvl;
  endfunction

endpackage

// File: rtl/core/crrs_ctrl.sv
`timescale 1ns / 1ps

module crrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  crrs_pkg::status_t status_i,
  output crrs_pkg::cmd_t    cmd_o
);

  crrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crrs_pkg::ST_IDLE: begin
        if (start) begin
          if (status_i.in_rel) begin
            state_d = crrs_pkg::ST_REL_RD;
          end else if (status_i.in_trivial) begin
            state_d = crrs_pkg::ST_APPEND;
          end else begin
            state_d = crrs_pkg::ST_SCAN_RD;
          end
        end
      end
      crrs_pkg::ST_SCAN_RD: state_d = crrs_pkg::ST_SCAN_CHK;
      crrs_pkg::ST_SCAN_CHK: begin
        if (status_i.hit || status_i.last) begin
          state_d = crrs_pkg::ST_APPEND;
        end else begin
          state_d = crrs_pkg::ST_SCAN_RD;
        end
      end
      crrs_pkg::ST_APPEND:  state_d = crrs_pkg::ST_OPEN;
      crrs_pkg::ST_OPEN:    state_d = crrs_pkg::ST_IDLE;
      crrs_pkg::ST_REL_RD:  state_d = crrs_pkg::ST_REL_CHK;
      crrs_pkg::ST_REL_CHK: state_d = crrs_pkg::ST_IDLE;
      default:              state_d = crrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      crrs_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      crrs_pkg::ST_SCAN_RD:  cmd_o.rd = 1'b1;
      crrs_pkg::ST_SCAN_CHK: cmd_o.chk = 1'b1;
      crrs_pkg::ST_APPEND:   cmd_o.wr_app = 1'b1;
      crrs_pkg::ST_OPEN: begin
        cmd_o.wr_open = 1'b1;
        cmd_o.finish  = 1'b1;
      end
      crrs_pkg::ST_REL_RD:   cmd_o.rd = 1'b1;
      crrs_pkg::ST_REL_CHK: begin
        cmd_o.rel    = 1'b1;
        cmd_o.finish = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/core/crrs_dpath.sv
`timescale 1ns / 1ps

module crrs_dpath #(
  parameter int SlotCount = crrs_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crrs_pkg::frame_t  frame_i,
  input  crrs_pkg::cmd_t    cmd_i,
  output crrs_pkg::status_t status_o,
  output crrs_pkg::result_t result_o,
  output logic              result_valid_o
);

  localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int IdW  = crrs_pkg::IdWidth;
  localparam int LenW = crrs_pkg::LenWidth;
  localparam int DatW = crrs_pkg::DataWidth;
  localparam int BytN = crrs_pkg::ByteCount;
  localparam int SlW  = crrs_pkg::SlotFieldWidth;

  crrs_pkg::slot_t    mem_q [SlotCount];
  crrs_pkg::slot_t    rd_q;
  crrs_pkg::slot_t    ent;
  crrs_pkg::slot_t    hit_ent_q;
  crrs_pkg::slot_t    wr_data;
  crrs_pkg::result_t  result_q, result_d;
  crrs_pkg::opcode_e  op_q;

  logic [SlotCount-1:0] valid_q;
  logic                 rd_vld_q;
  logic [IdxW-1:0]      addr_q;
  logic [IdxW-1:0]      hit_idx_q;
  logic [IdxW-1:0]      fre_idx_q;
  logic [IdxW-1:0]      wr_addr;
  logic                 hit_q;
  logic                 fre_q;
  logic                 rel_ok_q;
  logic                 res_valid_q;
  logic [IdW-1:0]       id_q;
  logic [LenW-1:0]      len_q;
  logic [LenW-1:0]      len_in;
  logic [DatW-1:0]      data_q;
  logic                 in_rel_ok;
  logic                 wr_en;

  logic                 app_en;
  logic                 open_en;
  logic [LenW-1:0]      start_pos;
  logic [LenW-1:0]      avail;
  logic [LenW-1:0]      used;
  logic [LenW-1:0]      rest;
  logic [DatW-1:0]      app_payload;
  logic [BytN-1:0]      app_mask;
  logic [DatW-1:0]      open_payload;
  logic [BytN-1:0]      open_mask;

  assign len_in    = (frame_i.frame_len > LenW'(BytN)) ? LenW'(BytN) : frame_i.frame_len;
  assign in_rel_ok = int'(frame_i.release_index) < SlotCount;

  assign ent = rd_vld_q ? rd_q : '0;

  assign status_o.in_rel     = (frame_i.opcode == crrs_pkg::OP_RELEASE);
  assign status_o.in_trivial = (frame_i.frame_id == '0) || (frame_i.frame_len == '0);
  assign status_o.hit        = (ent.ident == id_q);
  assign status_o.last       = (addr_q == '0);

  assign app_en    = hit_q && !hit_ent_q.mask[BytN-1];
  assign start_pos = crrs_pkg::fill_level(hit_ent_q.mask);
  assign avail     = LenW'(BytN) - start_pos;
  assign used      = app_en ? ((len_q < avail) ? len_q : avail) : '0;
  assign rest      = len_q - used;
  assign open_en   = fre_q && (rest != '0);

  assign app_payload  = hit_ent_q.payload
                      | ((data_q & crrs_pkg::byte_mask(used)) << {start_pos[2:0], 3'b000});
  assign app_mask     = hit_ent_q.mask | (crrs_pkg::bit_mask(used) << start_pos[2:0]);
  assign open_payload = (data_q >> {used[2:0], 3'b000}) & crrs_pkg::byte_mask(rest);
  assign open_mask    = crrs_pkg::bit_mask(rest);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_q;
    wr_data = '{ident: id_q, payload: app_payload, mask: app_mask};
    if (cmd_i.wr_app && app_en) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_open && open_en) begin
      wr_en   = 1'b1;
      wr_addr = fre_idx_q;
      wr_data = '{ident: id_q, payload: open_payload, mask: open_mask};
    end
  end

  always_comb begin
    result_d = '0;
    if (op_q == crrs_pkg::OP_RELEASE) begin
      if (rel_ok_q) begin
        result_d.slot_id_out    = ent.ident;
        result_d.slot_bytes_out = ent.payload;
        result_d.slot_mask_out  = ent.mask;
      end
    end else begin
      result_d.appended       = app_en;
      result_d.appended_slot  = app_en ? SlW'(hit_idx_q) : '0;
      result_d.appended_count = used;
      result_d.opened         = open_en;
      result_d.opened_slot    = open_en ? SlW'(fre_idx_q) : '0;
      result_d.opened_count   = open_en ? rest : '0;
      result_d.dropped_count  = fre_q ? '0 : rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= frame_i.frame_id;
      len_q  <= status_o.in_trivial ? '0 : len_in;
      data_q <= frame_i.frame_bytes;
    end
    if (cmd_i.chk) begin
      if (status_o.hit) begin
        hit_idx_q <= addr_q;
        hit_ent_q <= ent;
      end else if (ent.ident == '0) begin
        fre_idx_q <= addr_q;
      end
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= crrs_pkg::OP_FRAME;
      addr_q      <= '0;
      hit_q       <= 1'b0;
      fre_q       <= 1'b0;
      rel_ok_q    <= 1'b0;
      res_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
    end else begin
      res_valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        op_q     <= frame_i.opcode;
        hit_q    <= 1'b0;
        fre_q    <= 1'b0;
        rel_ok_q <= in_rel_ok;
        if (status_o.in_rel) begin
          addr_q <= in_rel_ok ? IdxW'(frame_i.release_index) : '0;
        end else begin
          addr_q <= IdxW'(SlotCount - 1);
        end
      end
      if (cmd_i.rd) begin
        rd_vld_q <= valid_q[addr_q];
      end
      if (cmd_i.chk) begin
        if (status_o.hit) begin
          hit_q <= 1'b1;
        end else begin
          if (ent.ident == '0) begin
            fre_q <= 1'b1;
          end
          if (addr_q != '0) begin
            addr_q <= addr_q - 1'b1;
          end
        end
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rel && rel_ok_q) begin
        valid_q[addr_q] <= 1'b0;
      end
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = res_valid_q;

  a_byte_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (5'(result_q.appended_count) + 5'(result_q.opened_count)
                     + 5'(result_q.dropped_count)) <= 5'(BytN))
    else $error("Result accounts for more bytes than a frame carries.");

  a_open_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_open && open_en) |-> !valid_q[fre_idx_q])
    else $error("A slot in use was claimed as free.");

  a_write_frame_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (op_q == crrs_pkg::OP_FRAME))
    else $error("Slot write during a release.");

  a_release_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && op_q == crrs_pkg::OP_RELEASE) |->
      (!result_q.appended && !result_q.opened && result_q.dropped_count == '0))
    else $error("Release result carries frame counts.");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("Result strobe held longer than one cycle.");

endmodule

// File: rtl/core/can_rx_reassembly_slots_core.sv
`timescale 1ns / 1ps

// Reassembles received CAN payloads into a table of SlotCount eight-byte slots. A command is
// taken when start is high and busy is low; its single result appears on result_o for exactly
// one cycle with result_valid_o high, and the receiver cannot stall it, so it must take the
// transfer in that cycle. A received frame scans the slot memory one entry at a time (a read
// state, then a check state) from the highest slot down, stopping at a matching identifier or
// at slot zero, then does the append write and after it the new-slot write. A release reads
// and frees the indexed slot, when in range, without a scan; a frame with identifier zero or an
// empty frame skips the scan. The next command may start in the cycle the result is shown.

module can_rx_reassembly_slots_core #(
  parameter int SlotCount = crrs_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  crrs_pkg::frame_t  frame_i,
  output crrs_pkg::result_t result_o,
  output logic              result_valid_o
);

  crrs_pkg::cmd_t    cmd;
  crrs_pkg::status_t status;

  crrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  crrs_dpath #(
    .SlotCount (SlotCount)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (frame_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// File: verif/tb_can_rx_reassembly_slots_core.sv
`timescale 1ns / 1ps

module tb_can_rx_reassembly_slots_core;

  localparam int Slots       = crrs_pkg::SlotCountDefault;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 2 * Slots + 8;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  crrs_pkg::frame_t  frame_i;
  crrs_pkg::result_t result_o;
  logic              result_valid_o;

  logic [crrs_pkg::IdWidth-1:0]   slot_ident_q   [Slots];
  logic [crrs_pkg::DataWidth-1:0] slot_payload_q [Slots];
  logic [crrs_pkg::ByteCount-1:0] slot_mask_q    [Slots];
  logic [crrs_pkg::IdWidth-1:0]   id_pool        [5];

  crrs_pkg::result_t pending_results[$];
  int                mismatch_count;
  int                cycle_count;
  int                sender_idle_pct;
  int                frames_seen;
  int                releases_seen;
  int                appends_seen;
  int                opens_seen;
  int                drops_seen;

  can_rx_reassembly_slots_core #(
    .SlotCount(Slots)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .frame_i       (frame_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  function automatic crrs_pkg::result_t reassemble(input crrs_pkg::frame_t f);
    crrs_pkg::result_t r;
    int                len;
    int                used;
    int                hit;
    int                fre;
    int                fill;
    int                rest;
    r = '0;
    if (f.opcode == crrs_pkg::OP_RELEASE) begin
      releases_seen++;
      r.slot_id_out    = slot_ident_q[f.release_index];
      r.slot_bytes_out = slot_payload_q[f.release_index];
      r.slot_mask_out  = slot_mask_q[f.release_index];
      slot_ident_q[f.release_index]   = '0;
      slot_payload_q[f.release_index] = '0;
      slot_mask_q[f.release_index]    = '0;
      return r;
    end
    frames_seen++;
    len  = (f.frame_len > 4'd8) ? 8 : int'(f.frame_len);
    used = 0;
    hit  = -1;
    fre  = -1;
    if (f.frame_id == '0 || len == 0) begin
      return r;
    end
    for (int i = Slots - 1; i >= 0; i--) begin
      if (slot_ident_q[i] == f.frame_id) begin
        hit = i;
        break;
      end else if (slot_ident_q[i] == '0) begin
        fre = i;
      end
    end
    if (hit >= 0 && !slot_mask_q[hit][crrs_pkg::ByteCount-1]) begin
      fill = 0;
      for (int p = 0; p < crrs_pkg::ByteCount; p++) begin
        if (slot_mask_q[hit][p]) begin
          fill = p + 1;
        end
      end
      for (int p = fill; p < crrs_pkg::ByteCount && used < len; p++) begin
        slot_payload_q[hit][8*p +: 8] = f.frame_bytes[8*used +: 8];
        slot_mask_q[hit][p] = 1'b1;
        used++;
      end
      if (used > 0) begin
        r.appended       = 1'b1;
        r.appended_slot  = crrs_pkg::SlotFieldWidth'(hit);
        r.appended_count = crrs_pkg::LenWidth'(used);
        appends_seen++;
      end
    end
    if (used < len) begin
      rest = len - used;
      if (fre >= 0) begin
        slot_ident_q[fre]   = f.frame_id;
        slot_payload_q[fre] = '0;
        slot_mask_q[fre]    = '0;
        for (int p = 0; p < rest; p++) begin
          slot_payload_q[fre][8*p +: 8] = f.frame_bytes[8*(used+p) +: 8];
          slot_mask_q[fre][p] = 1'b1;
        end
        r.opened       = 1'b1;
        r.opened_slot  = crrs_pkg::SlotFieldWidth'(fre);
        r.opened_count = crrs_pkg::LenWidth'(rest);
        opens_seen++;
      end else begin
        r.dropped_count = crrs_pkg::LenWidth'(rest);
        drops_seen++;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    crrs_pkg::result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transfer outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("appended", 64'(result_o.appended), 64'(want.appended));
          check_field("appended_slot", 64'(result_o.appended_slot),
                      64'(want.appended_slot));
          check_field("appended_count", 64'(result_o.appended_count),
                      64'(want.appended_count));
          check_field("opened", 64'(result_o.opened), 64'(want.opened));
          check_field("opened_slot", 64'(result_o.opened_slot), 64'(want.opened_slot));
          check_field("opened_count", 64'(result_o.opened_count),
                      64'(want.opened_count));
          check_field("dropped_count", 64'(result_o.dropped_count),
                      64'(want.dropped_count));
          check_field("slot_id_out", 64'(result_o.slot_id_out), 64'(want.slot_id_out));
          check_field("slot_bytes_out", result_o.slot_bytes_out, want.slot_bytes_out);
          check_field("slot_mask_out", 64'(result_o.slot_mask_out),
                      64'(want.slot_mask_out));
        end
      end
      if (start && !busy) begin
        pending_results.push_back(reassemble(frame_i));
      end
    end
  end

  task automatic send_frame(input crrs_pkg::frame_t f);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start   = 1'b1;
    frame_i = f;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_rx(input logic [crrs_pkg::IdWidth-1:0] id,
                         input logic [crrs_pkg::LenWidth-1:0] len,
                         input logic [crrs_pkg::DataWidth-1:0] data);
    crrs_pkg::frame_t f;
    f.opcode        = crrs_pkg::OP_FRAME;
    f.frame_id      = id;
    f.frame_len     = len;
    f.frame_bytes   = data;
    f.release_index = crrs_pkg::SlotFieldWidth'($urandom());
    send_frame(f);
  endtask

  task automatic send_release(input int index);
    crrs_pkg::frame_t f;
    f.opcode        = crrs_pkg::OP_RELEASE;
    f.frame_id      = crrs_pkg::IdWidth'($urandom());
    f.frame_len     = crrs_pkg::LenWidth'($urandom());
    f.frame_bytes   = {$urandom(), $urandom()};
    f.release_index = crrs_pkg::SlotFieldWidth'(index);
    send_frame(f);
  endtask

  function automatic crrs_pkg::frame_t random_frame();
    crrs_pkg::frame_t f;
    int               pick;
    f.opcode        = crrs_pkg::OP_FRAME;
    f.frame_id      = crrs_pkg::IdWidth'($urandom());
    f.frame_bytes   = {$urandom(), $urandom()};
    f.release_index = crrs_pkg::SlotFieldWidth'($urandom());
    f.frame_len     = ($urandom_range(0, 9) == 0) ?
                      crrs_pkg::LenWidth'($urandom_range(0, 15)) :
                      crrs_pkg::LenWidth'($urandom_range(1, 8));
    if ($urandom_range(0, 99) < 28) begin
      f.opcode = crrs_pkg::OP_RELEASE;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        f.frame_id = '0;
      end else if (pick > 1) begin
        f.frame_id = id_pool[pick % 5];
      end
    end
    return f;
  endfunction

  task automatic test_release_of_free_slots();
    send_release(0);
    send_release(Slots - 1);
  endtask

  task automatic test_ignored_frames();
    send_rx('0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_rx(29'h0AAA_AAAA, 4'd0, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_append_and_overflow();
    send_rx(29'h0AAA_AAAA, 4'd3, 64'h1111_1111_1133_2211);
    send_rx(29'h0AAA_AAAA, 4'd5, 64'h2222_2288_7766_5544);
    send_rx(29'h0AAA_AAAA, 4'd15, 64'hFFEE_DDCC_BBAA_9988);
    send_rx(29'h0AAA_AAAA, 4'd2, 64'h0000_0000_0000_0102);
    send_rx(29'h0AAA_AAAA, 4'd8, {$urandom(), $urandom()});
    send_rx(29'h1FFF_FFFF, 4'd1, 64'h0000_0000_0000_00FF);
  endtask

  task automatic test_table_full_drop();
    send_rx(29'h1555_5555, 4'd1, 64'h0000_0000_0000_00A5);
    send_rx(29'h0000_0002, 4'd1, 64'h0000_0000_0000_005A);
    send_rx(29'h0000_0003, 4'd1, 64'h0000_0000_0000_0001);
    send_rx(29'h0000_0003, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_rx(29'h0000_0009, 4'd4, 64'h0000_0000_DEAD_BEEF);
    send_release(0);
    send_release(Slots - 1);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_frame(random_frame());
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    frame_i         = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    frames_seen     = 0;
    releases_seen   = 0;
    appends_seen    = 0;
    opens_seen      = 0;
    drops_seen      = 0;
    id_pool         = '{29'h0000_0001, 29'h1FFF_FFFF, 29'h0AAA_AAAA, 29'h1555_5555,
                        29'h0000_07FF};
    for (int i = 0; i < Slots; i++) begin
      slot_ident_q[i]   = '0;
      slot_payload_q[i] = '0;
      slot_mask_q[i]    = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct = 23;
    test_release_of_free_slots();
    test_ignored_frames();
    test_append_and_overflow();
    test_table_full_drop();
    test_random_traffic(270, 23);
    test_random_traffic(270, 78);
    test_random_traffic(270, 0);

    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d received frames and %0d slot releases.", frames_seen,
             releases_seen);
    $display("Frames appended %0d times, opened %0d slots and dropped bytes %0d times.",
             appends_seen, opens_seen, drops_seen);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
